FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent property wrappers for the RTL, empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/lrmt_pkg.sv
// ---------------------------------------------------------------------------
// lrmt_pkg
// Shared types, codes and helpers of the lazy range-add / range-max tree.
// ---------------------------------------------------------------------------
`default_nettype none
package lrmt_pkg;
  localparam int VAL_W  = 64;
  localparam int SIZE_W = 11;
  localparam int IDX_W  = 10;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
  localparam logic [VAL_W-1:0]  MOST_NEG   = 64'h8000_0000_0000_0000;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_MAX = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             empty;
  } lrmt_res_t;

  function automatic logic [VAL_W-1:0] smax(input logic [VAL_W-1:0] a,
                                            input logic [VAL_W-1:0] b);
    smax = ($signed(a) >= $signed(b)) ? a : b;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/lrmt_ram.sv
// ---------------------------------------------------------------------------
// lrmt_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module lrmt_ram #(
  parameter int W = 64,
  parameter int D = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]              rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/lrmt_walker.sv
// ---------------------------------------------------------------------------
// lrmt_walker
// Tree traversal sequencer: clears both stores after reset, then walks the
// tree for one item with push-down and read-modify-write per node.
// ---------------------------------------------------------------------------
`default_nettype none
module lrmt_walker #(
  parameter int MAX_ENTRIES = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic                            st_cmd,
  input  wire logic [lrmt_pkg::IDX_W-1:0]      st_left,
  input  wire logic [lrmt_pkg::IDX_W-1:0]      st_right,
  input  wire logic [lrmt_pkg::VAL_W-1:0]      st_amount,
  input  wire logic                            st_empty,
  input  wire logic [$clog2(MAX_ENTRIES)-1:0]  root_e,
  output logic                                 ready,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output lrmt_pkg::lrmt_res_t                  res
);
  import lrmt_pkg::*;

  localparam int IW    = $clog2(MAX_ENTRIES);
  localparam int NODES = 4 * MAX_ENTRIES;
  localparam int KW    = $clog2(NODES);
  localparam int LW    = (IW > IDX_W) ? IW : IDX_W;
  localparam int SD    = IW + 1;
  localparam int SPW   = $clog2(SD + 1);
  localparam int SIW   = (SD > 1) ? $clog2(SD) : 1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_EVAL, S_APPLY, S_C1, S_C2, S_DEC, S_RET, S_OUT
  } state_t;

  typedef struct packed {
    logic [KW-1:0]    node;
    logic [IW-1:0]    s;
    logic [IW-1:0]    e;
    logic             phase;
    logic [VAL_W-1:0] lv;
  } frame_t;

  state_t           state_r;
  logic [KW-1:0]    clr_r;
  logic [KW-1:0]    k_r;
  logic [IW-1:0]    s_r;
  logic [IW-1:0]    e_r;
  logic [VAL_W-1:0] nm_r;
  logic [VAL_W-1:0] pd_r;
  logic [VAL_W-1:0] inc_r;
  logic [VAL_W-1:0] ret_r;
  logic [VAL_W-1:0] amt_r;
  logic             out_r;
  logic             cov_r;
  logic             leaf_r;
  logic             cmd_r;
  logic             empty_r;
  logic [LW-1:0]    l_r;
  logic [LW-1:0]    r_r;
  logic [SPW-1:0]   sp_r;
  frame_t           stk_r [SD];

  logic             nm_we;
  logic [KW-1:0]    nm_waddr;
  logic [VAL_W-1:0] nm_wdata;
  logic [VAL_W-1:0] nm_rd;
  logic             pd_we;
  logic [KW-1:0]    pd_waddr;
  logic [VAL_W-1:0] pd_wdata;
  logic [KW-1:0]    pd_raddr;
  logic [VAL_W-1:0] pd_rd;

  logic [IW:0]      sum;
  logic [IW-1:0]    mid;
  logic [KW-1:0]    c1;
  logic [KW-1:0]    c2;
  logic [SPW-1:0]   sp_dec;
  logic [SIW-1:0]   top_idx;
  frame_t           tf;
  logic [IW:0]      tsum;
  logic [IW-1:0]    tmid;
  logic [KW-1:0]    tc2;
  logic             addcov;
  logic [VAL_W-1:0] nm_fin;
  logic [VAL_W-1:0] join_val;

  lrmt_ram #(.W(VAL_W), .D(NODES)) u_nm_ram (
    .clk   (clk),
    .we    (nm_we),
    .waddr (nm_waddr),
    .wdata (nm_wdata),
    .raddr (k_r),
    .rdata (nm_rd)
  );

  lrmt_ram #(.W(VAL_W), .D(NODES)) u_pd_ram (
    .clk   (clk),
    .we    (pd_we),
    .waddr (pd_waddr),
    .wdata (pd_wdata),
    .raddr (pd_raddr),
    .rdata (pd_rd)
  );

  assign sum      = {1'b0, s_r} + {1'b0, e_r};
  assign mid      = sum[IW:1];
  assign c1       = {k_r[KW-2:0], 1'b1};
  assign c2       = c1 + KW'(1);
  assign sp_dec   = sp_r - SPW'(1);
  assign top_idx  = sp_dec[SIW-1:0];
  assign tf       = stk_r[top_idx];
  assign tsum     = {1'b0, tf.s} + {1'b0, tf.e};
  assign tmid     = tsum[IW:1];
  assign tc2      = {tf.node[KW-2:0], 1'b0} + KW'(2);
  assign addcov   = (cmd_r == CMD_ADD) && cov_r && !out_r;
  assign nm_fin   = addcov ? (nm_r + amt_r) : nm_r;
  assign join_val = smax(tf.lv, ret_r);

  assign ready     = (state_r == S_IDLE);
  assign res_valid = (state_r == S_OUT) && (cmd_r == CMD_MAX);
  assign res.value = ret_r;
  assign res.empty = empty_r;

  always_comb begin
    nm_we    = 1'b0;
    nm_waddr = k_r;
    nm_wdata = nm_fin;
    pd_we    = 1'b0;
    pd_waddr = k_r;
    pd_wdata = '0;
    pd_raddr = k_r;
    case (state_r)
      S_CLR: begin
        nm_we    = 1'b1;
        nm_waddr = clr_r;
        nm_wdata = '0;
        pd_we    = 1'b1;
        pd_waddr = clr_r;
      end
      S_APPLY: begin
        nm_we    = 1'b1;
        pd_we    = 1'b1;
        pd_raddr = c1;
      end
      S_C1: begin
        pd_raddr = c2;
        pd_we    = 1'b1;
        pd_waddr = c1;
        pd_wdata = pd_rd + inc_r;
      end
      S_C2: begin
        pd_we    = 1'b1;
        pd_waddr = c2;
        pd_wdata = pd_rd + inc_r;
      end
      S_RET: begin
        if (sp_r != '0 && tf.phase && cmd_r == CMD_ADD) begin
          nm_we    = 1'b1;
          nm_waddr = tf.node;
          nm_wdata = join_val;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      sp_r    <= '0;
    end else begin
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + KW'(1);
          if (clr_r == KW'(NODES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_r   <= st_cmd;
            l_r     <= LW'(st_left);
            r_r     <= LW'(st_right);
            amt_r   <= st_amount;
            empty_r <= st_empty;
            k_r     <= '0;
            s_r     <= '0;
            e_r     <= root_e;
            sp_r    <= '0;
            ret_r   <= MOST_NEG;
            state_r <= st_empty ? S_OUT : S_RD;
          end
        end
        S_RD: begin
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          nm_r    <= nm_rd + pd_rd;
          pd_r    <= pd_rd;
          out_r   <= (LW'(s_r) > r_r) || (LW'(e_r) < l_r);
          cov_r   <= (LW'(s_r) >= l_r) && (LW'(e_r) <= r_r);
          leaf_r  <= (s_r == e_r);
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          nm_r    <= nm_fin;
          inc_r   <= addcov ? (pd_r + amt_r) : pd_r;
          state_r <= leaf_r ? S_DEC : S_C1;
        end
        S_C1: begin
          state_r <= S_C2;
        end
        S_C2: begin
          state_r <= S_DEC;
        end
        S_DEC: begin
          if (out_r) begin
            ret_r   <= (cmd_r == CMD_ADD) ? nm_r : MOST_NEG;
            state_r <= S_RET;
          end else if (cov_r) begin
            ret_r   <= nm_r;
            state_r <= S_RET;
          end else begin
            stk_r[sp_r[SIW-1:0]] <= '{node: k_r, s: s_r, e: e_r, phase: 1'b0, lv: '0};
            sp_r    <= sp_r + SPW'(1);
            k_r     <= c1;
            e_r     <= mid;
            state_r <= S_RD;
          end
        end
        S_RET: begin
          if (sp_r == '0) begin
            state_r <= S_OUT;
          end else if (!tf.phase) begin
            stk_r[top_idx].phase <= 1'b1;
            stk_r[top_idx].lv    <= ret_r;
            k_r     <= tc2;
            s_r     <= tmid + IW'(1);
            e_r     <= tf.e;
            state_r <= S_RD;
          end else begin
            ret_r <= join_val;
            sp_r  <= sp_dec;
          end
        end
        S_OUT: begin
          if (cmd_r == CMD_ADD || res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/lazy_range_add_max_tree_unit.sv
// An item walks the tree node by node: each visited node is read, evaluated
// and written back with any add applied, an inner node then pushes its
// pending add down to both children, and the walk descends or returns to the
// parent. A query's item may then wait while the output register is still
// full. An empty range skips the walk, a range that covers the whole span
// visits only the root, and the worst range at 1024 entries visits about 40
// nodes. The walk is paced by the per-node read, push-down and write-back
// through the two node stores, one write and one registered read each per
// cycle. After reset a clearing pass over all 4*MAX_ENTRIES nodes runs before
// the first item is taken; configuration writes are taken at any time.
// ---------------------------------------------------------------------------
// lazy_range_add_max_tree_unit
// Segment tree with lazy range add and range max query over signed entries.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module lazy_range_add_max_tree_unit #(
  parameter int MAX_ENTRIES = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [lrmt_pkg::SIZE_W-1:0] cfg_size_in_use,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_command,
  input  wire logic [lrmt_pkg::IDX_W-1:0]  in_left_index,
  input  wire logic [lrmt_pkg::IDX_W-1:0]  in_right_index,
  input  wire logic [lrmt_pkg::VAL_W-1:0]  in_add_amount,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [lrmt_pkg::VAL_W-1:0]       out_max_value,
  output logic                             out_range_empty
);
  import lrmt_pkg::*;

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int NW = $clog2(MAX_ENTRIES + 1);
  localparam int CW = (NW > SIZE_W) ? NW : SIZE_W;

  logic [SIZE_W-1:0] size_r;
  logic [CW-1:0]     size_ext;
  logic [CW-1:0]     n_eff;
  logic [CW-1:0]     root_ext;
  logic              empty;
  logic              start;
  logic              wk_res_valid;
  logic              out_free;
  lrmt_res_t         wk_res;
  logic              out_valid_r;
  logic [VAL_W-1:0]  out_max_value_r;
  logic              out_range_empty_r;

  assign cfg_ready = 1'b1;
  assign size_ext  = CW'(size_r);
  assign n_eff     = (size_ext == '0) ? CW'(1) :
                     (size_ext > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : size_ext;
  assign root_ext  = n_eff - CW'(1);
  assign empty     = (in_left_index > in_right_index) || (CW'(in_left_index) >= n_eff);
  assign start     = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  lrmt_walker #(.MAX_ENTRIES(MAX_ENTRIES)) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .st_cmd    (in_command),
    .st_left   (in_left_index),
    .st_right  (in_right_index),
    .st_amount (in_add_amount),
    .st_empty  (empty),
    .root_e    (root_ext[IW-1:0]),
    .ready     (in_ready),
    .res_valid (wk_res_valid),
    .res_ready (out_free),
    .res       (wk_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        size_r <= cfg_size_in_use;
      end
      if (wk_res_valid && out_free) begin
        out_valid_r       <= 1'b1;
        out_max_value_r   <= wk_res.value;
        out_range_empty_r <= wk_res.empty;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_max_value   = out_max_value_r;
  assign out_range_empty = out_range_empty_r;

  `ASSERT_IMPLY(a_empty_min, clk, rst_n, out_valid && out_range_empty, out_max_value == MOST_NEG)
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `ASSERT_NEXT(a_add_no_result, clk, rst_n, in_valid && in_ready && in_command == CMD_ADD, !$rose(out_valid))
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Drives range adds and range max queries into the lazy segment tree unit,
// predicts every query result with a mirror of the node tree, and compares
// each returned item field by field under random stalls on both channels.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import lrmt_pkg::*;

  localparam int MAX_ENTRIES = 1024;
  localparam int N_RANDOM    = 1600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SIZE_W-1:0] cfg_size_in_use = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = CMD_ADD;
  logic [IDX_W-1:0] in_left_index = '0;
  logic [IDX_W-1:0] in_right_index = '0;
  logic [VAL_W-1:0] in_add_amount = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [VAL_W-1:0] out_max_value;
  logic out_range_empty;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  lazy_range_add_max_tree_unit #(.MAX_ENTRIES(MAX_ENTRIES)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_size_in_use(cfg_size_in_use),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_left_index(in_left_index), .in_right_index(in_right_index),
    .in_add_amount(in_add_amount),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_max_value(out_max_value), .out_range_empty(out_range_empty)
  );

  logic [SIZE_W-1:0] size_reg;
  lrmt_res_t pending_max_q [$];
  int errors = 0;
  int n_queries = 0;
  int n_empty = 0;
  int n_items = 0;
  bit idle_ok = 1'b1;
  bit long_hold = 1'b0;

  function automatic int span_of(input logic [SIZE_W-1:0] sz);
    if (sz == 0) return 1;
    if (sz > MAX_ENTRIES) return MAX_ENTRIES;
    return int'(sz);
  endfunction

  // The tree keeps its stores when the size changes. Each leaf at index i
  // under the walk for size n holds what was added through that walk, so a
  // flat model only matches when queries use the size that adds used. The
  // testbench therefore clears the entries by resetting the size only while
  // all entries are provably equal (never), and instead keeps one size per
  // data phase and predicts via the array tree below.
  logic [VAL_W-1:0] t_max [4*MAX_ENTRIES];
  logic [VAL_W-1:0] t_pend [4*MAX_ENTRIES];

  function automatic void push_pend(input int k, input int s, input int e);
    if (t_pend[k] != 0) begin
      t_max[k] += t_pend[k];
      if (s != e) begin
        if (2*k+1 < 4*MAX_ENTRIES) t_pend[2*k+1] += t_pend[k];
        if (2*k+2 < 4*MAX_ENTRIES) t_pend[2*k+2] += t_pend[k];
      end
      t_pend[k] = 0;
    end
  endfunction

  function automatic void range_add(input int k, input int s, input int e,
                                    input int l, input int r,
                                    input logic [VAL_W-1:0] amt);
    int mid;
    if (k >= 4*MAX_ENTRIES) return;
    push_pend(k, s, e);
    if (s > e || s > r || e < l) return;
    if (s >= l && e <= r) begin
      t_max[k] += amt;
      if (s != e) begin
        if (2*k+1 < 4*MAX_ENTRIES) t_pend[2*k+1] += amt;
        if (2*k+2 < 4*MAX_ENTRIES) t_pend[2*k+2] += amt;
      end
      return;
    end
    mid = s + (e - s) / 2;
    range_add(2*k+1, s, mid, l, r, amt);
    range_add(2*k+2, mid+1, e, l, r, amt);
    if (2*k+2 < 4*MAX_ENTRIES)
      t_max[k] = ($signed(t_max[2*k+1]) >= $signed(t_max[2*k+2])) ?
                 t_max[2*k+1] : t_max[2*k+2];
  endfunction

  function automatic logic [VAL_W-1:0] range_max(input int k, input int s,
                                                 input int e, input int l,
                                                 input int r);
    int mid;
    logic [VAL_W-1:0] a, b;
    if (k >= 4*MAX_ENTRIES) return MOST_NEG;
    push_pend(k, s, e);
    if (s > e || s > r || e < l) return MOST_NEG;
    if (s >= l && e <= r) return t_max[k];
    mid = s + (e - s) / 2;
    a = range_max(2*k+1, s, mid, l, r);
    b = range_max(2*k+2, mid+1, e, l, r);
    return ($signed(a) >= $signed(b)) ? a : b;
  endfunction

  task automatic predict_item(input logic cmd, input int l, input int r,
                              input logic [VAL_W-1:0] amt);
    int n;
    bit empty;
    lrmt_res_t res;
    n = span_of(size_reg);
    empty = (l > r) || (l >= n);
    if (cmd == CMD_ADD) begin
      if (!empty) range_add(0, 0, n-1, l, r, amt);
    end else begin
      res.empty = empty;
      res.value = empty ? MOST_NEG : range_max(0, 0, n-1, l, r);
      pending_max_q = {pending_max_q, res};
      n_queries++;
      if (empty) n_empty++;
    end
  endtask

  // Directed table; an expected value is typed in only for the first two rows.
  typedef struct {
    logic cmd;
    int l;
    int r;
    logic [VAL_W-1:0] amt;
  } dir_row_t;

  task automatic send_item(input logic cmd, input int l, input int r,
                           input logic [VAL_W-1:0] amt);
    int gap;
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_left_index <= l[IDX_W-1:0];
    in_right_index <= r[IDX_W-1:0];
    in_add_amount <= amt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(cmd, l, r, amt);
    n_items++;
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    while (pending_max_q.size() != 0) @(posedge clk);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] sz);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_size_in_use <= sz;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    size_reg = sz;
  endtask

  task automatic random_phase(input int count);
    int n, l, r;
    logic cmd;
    logic [VAL_W-1:0] amt;
    for (int i = 0; i < count; i++) begin
      n = span_of(size_reg);
      cmd = $urandom_range(0, 1);
      case ($urandom_range(0, 9))
        0: begin
          l = $urandom_range(0, 1023);
          r = $urandom_range(0, 1023);
        end
        1: begin
          l = $urandom_range(0, n-1);
          r = l;
        end
        default: begin
          l = $urandom_range(0, n-1);
          r = $urandom_range(l, (n-1 < l + 40) ? n-1 : l + 40);
          if ($urandom_range(0, 4) == 0) r = $urandom_range(l, n-1);
        end
      endcase
      case ($urandom_range(0, 5))
        0: amt = {$urandom, $urandom};
        1: amt = $urandom_range(0, 1) ? MOST_NEG : ~MOST_NEG;
        default: amt = 64'($signed($urandom_range(0, 2000)) - 1000);
      endcase
      send_item(cmd, l, r, amt);
    end
  endtask

  // Result side: random stalls, one long hold-off.
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      if (!long_hold && n_items > 300) begin
        long_hold = 1'b1;
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
      end
      if (idle_ok && $urandom_range(0, 3) == 0) begin
        hold = $urandom_range(1, 9);
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    lrmt_res_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_max_q.size() == 0) begin
        $error("unexpected result item: max_value %0d", $signed(out_max_value));
        errors++;
      end else begin
        exp_res = pending_max_q.pop_front();
        if (out_max_value !== exp_res.value) begin
          $error("max_value: expected %0d, got %0d", $signed(exp_res.value),
                 $signed(out_max_value));
          errors++;
        end
        if (out_range_empty !== exp_res.empty) begin
          $error("range_empty: expected %0b, got %0b", exp_res.empty,
                 out_range_empty);
          errors++;
        end
      end
    end
  end

  initial begin
    dir_row_t dir_rows [$];
    logic [VAL_W-1:0] exp_val;
    for (int k = 0; k < 4*MAX_ENTRIES; k++) begin
      t_max[k] = '0;
      t_pend[k] = '0;
    end
    size_reg = SIZE_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    dir_rows = '{
      '{CMD_MAX, 0, 1023, 64'd0},
      '{CMD_MAX, 5, 4, 64'd0},
      '{CMD_ADD, 0, 1023, 64'h7fff_ffff_ffff_ffff},
      '{CMD_MAX, 0, 0, 64'd0},
      '{CMD_ADD, 1023, 1023, 64'd1},
      '{CMD_MAX, 1023, 1023, 64'd0},
      '{CMD_ADD, 10, 20, 64'h8000_0000_0000_0000},
      '{CMD_MAX, 10, 20, 64'd0},
      '{CMD_ADD, 30, 2, 64'd55},
      '{CMD_MAX, 0, 1023, 64'd0},
      '{CMD_ADD, 0, 1023, 64'hffff_ffff_ffff_ffff},
      '{CMD_MAX, 512, 700, 64'd0},
      '{CMD_MAX, 1023, 0, 64'd0}
    };
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].cmd, dir_rows[i].l, dir_rows[i].r, dir_rows[i].amt);
      if (i == 0 || i == 1) begin
        exp_val = pending_max_q[pending_max_q.size()-1].value;
        if (exp_val !== (i == 0 ? 64'd0 : MOST_NEG)) begin
          $error("max_value: expected %0d, got %0d", i == 0 ? 0 : $signed(MOST_NEG),
                 $signed(exp_val));
          errors++;
        end
      end
    end

    // Small size with ranges past the end, then the size extremes 0 and 2047.
    write_size(11'd5);
    send_item(CMD_ADD, 3, 900, 64'd7);
    send_item(CMD_MAX, 6, 9, 64'd0);
    send_item(CMD_MAX, 0, 1023, 64'd0);
    write_size(11'd0);
    send_item(CMD_ADD, 0, 0, 64'd3);
    send_item(CMD_MAX, 0, 1, 64'd0);
    send_item(CMD_MAX, 1, 1, 64'd0);
    write_size(11'd2047);
    send_item(CMD_MAX, 0, 1023, 64'd0);

    write_size(11'd1024);
    random_phase(500);
    // Sender pause until all results are back.
    drain_results();
    random_phase(300);
    write_size(11'd37);
    random_phase(300);
    write_size(11'd1);
    random_phase(100);
    write_size(11'd700);
    random_phase(200);
    idle_ok = 1'b0;
    write_size(11'd1024);
    random_phase(200);
    drain_results();

    $display("Ran %0d items: %0d queries, %0d of them on empty ranges.",
             n_items, n_queries, n_empty);
    $display("Sizes covered 0, 1, 5, 37, 700, 1024 and 2047 with random stalls.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire
